// ----- hdl/sm64_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm64_pkg
// Types, constants and the control store of the splitmix64 range generator.
// ----------------------------------------------------------------------------
package sm64_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned HALF_W  = WORD_W / 2;
    localparam int unsigned PC_W    = 4;
    localparam int unsigned CNT_W   = $clog2(WORD_W);

    localparam logic [WORD_W-1:0] GOLDEN_INC = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] MIX_MUL_A  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [WORD_W-1:0] MIX_MUL_B  = 64'h94D0_49BB_1331_11EB;
    localparam logic [WORD_W-1:0] SEED_RESET = 64'h9E37_79B9_7F4A_7C15;
    localparam int unsigned MIX_SHIFT_A = 30;
    localparam int unsigned MIX_SHIFT_B = 27;
    localparam int unsigned MIX_SHIFT_C = 31;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WORD_W - 1);

    typedef logic [PC_W-1:0] t_pc;

    // program steps
    localparam t_pc STEP_WAIT = 4'd0;
    localparam t_pc STEP_XSA  = 4'd1;
    localparam t_pc STEP_XSB  = 4'd7;
    localparam t_pc STEP_XSC  = 4'd13;
    localparam t_pc STEP_DIV  = 4'd14;
    localparam t_pc STEP_OUT  = 4'd15;

    typedef enum logic [3:0] {
        OP_LOAD,    // take transaction, advance state
        OP_XSA,     // z ^= z >> 30
        OP_MLL,     // acc = z_lo * k_lo
        OP_MLH,     // prod = z_lo * k_hi
        OP_MHL,     // prod = z_hi * k_lo
        OP_ADH,     // acc += prod_lo << 32
        OP_XSB,     // z = acc ^ (acc >> 27)
        OP_XSC,     // z = acc ^ (acc >> 31), start division
        OP_DIV,     // one restoring division bit
        OP_OUT      // load output register
    } t_op;

    typedef enum logic [2:0] {
        COND_NEXT,      // fall through
        COND_NO_IN,     // jump while no transaction
        COND_BND_ZERO,  // jump when bound is zero
        COND_LOOP,      // jump while division bits remain
        COND_OUT_BUSY   // jump while output register is held
    } t_cond;

    typedef enum logic {
        KSEL_A,
        KSEL_B
    } t_ksel;

    typedef struct packed {
        t_op   op;
        t_ksel ksel;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // Control store. Step 15 falls through to step 0 by wrap of the counter.
    function automatic t_uword ucode(input t_pc pc);
        t_uword uw;
        uw = '{op: OP_OUT, ksel: KSEL_A, cond: COND_NEXT, target: STEP_WAIT};
        case (pc)
            4'd0:  uw = '{OP_LOAD, KSEL_A, COND_NO_IN,    STEP_WAIT};
            4'd1:  uw = '{OP_XSA,  KSEL_A, COND_NEXT,     STEP_WAIT};
            4'd2:  uw = '{OP_MLL,  KSEL_A, COND_NEXT,     STEP_WAIT};
            4'd3:  uw = '{OP_MLH,  KSEL_A, COND_NEXT,     STEP_WAIT};
            4'd4:  uw = '{OP_ADH,  KSEL_A, COND_NEXT,     STEP_WAIT};
            4'd5:  uw = '{OP_MHL,  KSEL_A, COND_NEXT,     STEP_WAIT};
            4'd6:  uw = '{OP_ADH,  KSEL_A, COND_NEXT,     STEP_WAIT};
            4'd7:  uw = '{OP_XSB,  KSEL_B, COND_NEXT,     STEP_WAIT};
            4'd8:  uw = '{OP_MLL,  KSEL_B, COND_NEXT,     STEP_WAIT};
            4'd9:  uw = '{OP_MLH,  KSEL_B, COND_NEXT,     STEP_WAIT};
            4'd10: uw = '{OP_ADH,  KSEL_B, COND_NEXT,     STEP_WAIT};
            4'd11: uw = '{OP_MHL,  KSEL_B, COND_NEXT,     STEP_WAIT};
            4'd12: uw = '{OP_ADH,  KSEL_B, COND_NEXT,     STEP_WAIT};
            4'd13: uw = '{OP_XSC,  KSEL_B, COND_BND_ZERO, STEP_OUT};
            4'd14: uw = '{OP_DIV,  KSEL_B, COND_LOOP,     STEP_DIV};
            4'd15: uw = '{OP_OUT,  KSEL_B, COND_OUT_BUSY, STEP_OUT};
            default: uw = '{OP_OUT, KSEL_A, COND_NEXT,    STEP_WAIT};
        endcase
        return uw;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/splitmix64_range_generator.sv -----
// ----------------------------------------------------------------------------
// splitmix64_range_generator
// splitmix64 generator with reduction of each output modulo a bound.
//
// Input stream: i_s_tdata carries range_bound. Each transaction advances the
// generator state by the golden-ratio increment and yields one output
// transaction carrying raw_value and bounded_value (zero for a zero bound).
// Seed port: i_cfg_wr_en/i_cfg_wr_data load the generator state; write only
// while the block is idle.
// Sequencing: a microcoded sequencer runs a 16-step program. Each 64-bit
// multiply runs as the steps MLL, MLH, ADH, MHL, ADH on one 32x32
// multiplier, and the remainder comes from a one-bit restoring divider
// that does one bit per step and is skipped for a zero bound. The next
// transaction is taken only once the result is in the output register.
// o_s_tready is high only while the program waits at its first step.
// The finished result sits in an output register; if the receiver stalls
// with a result still held, the next item waits at the last step.
// Reset loads the state with 0x9E3779B97F4A7C15 and empties the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module splitmix64_range_generator
    import sm64_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    input  wire logic [WORD_W-1:0]   i_s_tdata,      // [63:0] range_bound
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    output logic [2*WORD_W-1:0]      o_m_tdata,      // [63:0] raw_value,
                                                     // [127:64] bounded_value
    input  wire logic                i_cfg_wr_en,
    input  wire logic [WORD_W-1:0]   i_cfg_wr_data
);

    t_pc                r_pc;
    t_pc                n_pc;
    t_uword             w_uw;
    logic               w_accept;
    logic               w_out_busy;
    logic               w_jump;

    logic [WORD_W-1:0]  r_state;
    logic [WORD_W-1:0]  r_z;
    logic [WORD_W-1:0]  r_acc;
    logic [WORD_W-1:0]  r_prod;
    logic [WORD_W-1:0]  r_bound;
    logic [WORD_W-1:0]  r_rem;
    logic [WORD_W-1:0]  r_quo;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_m_tvalid;
    logic [WORD_W-1:0]  r_raw_out;
    logic [WORD_W-1:0]  r_bnd_out;

    logic [WORD_W-1:0]  w_k;
    logic [HALF_W-1:0]  w_mul_a;
    logic [HALF_W-1:0]  w_mul_b;
    logic [WORD_W-1:0]  w_prod;
    logic [WORD_W-1:0]  w_adv;
    logic [WORD_W:0]    w_rem_sh;
    logic [WORD_W:0]    w_rem_sub;

    assign w_uw       = ucode(r_pc);
    assign o_s_tready = (r_pc == STEP_WAIT);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_busy = r_m_tvalid && !i_m_tready;
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {r_bnd_out, r_raw_out};

    // sequencer
    always_comb begin
        case (w_uw.cond)
            COND_NEXT:     w_jump = 1'b0;
            COND_NO_IN:    w_jump = !w_accept;
            COND_BND_ZERO: w_jump = (r_bound == '0);
            COND_LOOP:     w_jump = (r_cnt != DIV_LAST);
            COND_OUT_BUSY: w_jump = w_out_busy;
            default:       w_jump = 1'b0;
        endcase
        n_pc = w_jump ? w_uw.target : t_pc'(r_pc + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    // datapath
    assign w_k      = (w_uw.ksel == KSEL_B) ? MIX_MUL_B : MIX_MUL_A;
    assign w_mul_a  = (w_uw.op == OP_MHL) ? r_z[WORD_W-1:HALF_W] : r_z[HALF_W-1:0];
    assign w_mul_b  = (w_uw.op == OP_MLH) ? w_k[WORD_W-1:HALF_W] : w_k[HALF_W-1:0];
    assign w_prod   = WORD_W'(w_mul_a) * WORD_W'(w_mul_b);
    assign w_adv    = r_state + GOLDEN_INC;
    assign w_rem_sh = {r_rem, r_quo[WORD_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_bound};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEED_RESET;
        end else if (i_cfg_wr_en) begin
            r_state <= i_cfg_wr_data;
        end else if (w_uw.op == OP_LOAD && w_accept) begin
            r_state <= w_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        case (w_uw.op)
            OP_LOAD: begin
                if (w_accept) begin
                    r_bound <= i_s_tdata;
                    r_z     <= w_adv;
                end
            end
            OP_XSA: r_z    <= r_z ^ (r_z >> MIX_SHIFT_A);
            OP_MLL: r_acc  <= w_prod;
            OP_MLH: r_prod <= w_prod;
            OP_MHL: r_prod <= w_prod;
            OP_ADH: r_acc  <= r_acc + {r_prod[HALF_W-1:0], {HALF_W{1'b0}}};
            OP_XSB: r_z    <= r_acc ^ (r_acc >> MIX_SHIFT_B);
            OP_XSC: begin
                r_z   <= r_acc ^ (r_acc >> MIX_SHIFT_C);
                r_quo <= r_acc ^ (r_acc >> MIX_SHIFT_C);
                r_rem <= '0;
                r_cnt <= '0;
            end
            OP_DIV: begin
                r_rem <= w_rem_sub[WORD_W] ? w_rem_sh[WORD_W-1:0] : w_rem_sub[WORD_W-1:0];
                r_quo <= {r_quo[WORD_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
            end
            OP_OUT: begin
                if (!w_out_busy) begin
                    r_raw_out <= r_z;
                    r_bnd_out <= (r_bound == '0) ? '0 : r_rem;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_uw.op == OP_OUT && !w_out_busy) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_pc == STEP_XSA)
        else $error("accepted transaction did not start the program");

    a_div_loops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == STEP_DIV && r_cnt != DIV_LAST) |=> r_pc == STEP_DIV)
        else $error("division left before all bits were done");

    a_rem_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pc == STEP_DIV || r_pc == STEP_OUT) && r_bound != '0) |-> r_rem < r_bound)
        else $error("partial remainder not below bound");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_tvalid) |-> $past(r_pc) == STEP_OUT)
        else $error("output valid raised outside the output step");

    a_busy_no_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == STEP_OUT && w_out_busy) |=> r_pc == STEP_OUT)
        else $error("result overwrote a held output");
`endif

endmodule
`default_nettype wire
